// ===== hdl/pawp_pkg.sv =====
// Shared types and constants of the poison access watchpoint.
package pawp_pkg;

	localparam int SITE_SLOTS_DEF = 48;
	localparam int ADDR_W = 64;
	localparam int DATA_W = 64;
	localparam int CNT_W = 32;
	localparam int SITES_OUT_W = 6;
	localparam int CFG_IDX_W = 8;
	localparam int WCODE_W = 3;

	// Stream payload layout
	localparam int S_TDATA_W = 264;
	localparam int M_TDATA_W = 40;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 8'd3;

	// Access width codes
	localparam logic [WCODE_W-1:0] WC_1B = 3'd0;
	localparam logic [WCODE_W-1:0] WC_2B = 3'd1;
	localparam logic [WCODE_W-1:0] WC_4B = 3'd2;
	localparam logic [WCODE_W-1:0] WC_8B = 3'd3;
	localparam logic [WCODE_W-1:0] WC_16B = 3'd4;

	localparam logic [7:0] POISON_BYTE = 8'hAA;
	localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic pattern_mode;
		logic [DATA_W-1:0] target_value;
		logic [ADDR_W-1:0] window_low;
		logic [ADDR_W-1:0] window_high;
	} cfg_t;

	typedef struct packed {
		logic is_write;
		logic [WCODE_W-1:0] width_code;
		logic [ADDR_W-1:0] access_address;
		logic [DATA_W-1:0] data_low;
		logic [DATA_W-1:0] data_high;
		logic [ADDR_W-1:0] instr_address;
	} access_t;

	// Classified access handed from the front to the back
	typedef struct packed {
		logic hit;
		logic [ADDR_W-1:0] pc;
	} qent_t;

	// Queue status seen by the back
	typedef struct packed {
		logic valid;
		qent_t ent;
	} qhead_t;

endpackage

// ===== hdl/poison_access_watchpoint.sv =====
// Top level of the poison access watchpoint: ports, configuration registers, front, queue, back.
//
// Watches a stream of traced memory accesses, one transaction per access, and returns one
// result transaction per access. An access hits when its data is all 0xAA bytes (pattern
// mode) or equals target_value (value mode), and its address lies in [window_low,
// window_high) unless both bounds are zero. Hits advance a 32-bit saturating counter, and the
// instruction address of a hit is looked up in a table of SITE_SLOTS recorded sites; an
// unknown one is appended and flagged as new_site while the table has room. The front
// classifies an access in the cycle it is accepted and drops it into a two-entry queue, so
// input keeps flowing while the back works and the queue has room. For a non-hit, or a hit with
// an empty or full table, the back goes from idle straight to its output state; a hit passes a
// read and a compare state per recorded site scanned, as the site table is a memory with a
// single registered read port searched one entry at a time. Results wait in an output register,
// so a stalled consumer does not stop the back before the next result is ready. Configuration
// writes are taken every cycle; write them only while no access is in flight. Register indexes:
// 0 pattern_mode, 1 target_value, 2 window_low, 3 window_high; other indexes are ignored.
module poison_access_watchpoint #(
	parameter int SITE_SLOTS = pawp_pkg::SITE_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Access input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// width_code[2:0], access_address[66:3], data_low[130:67], data_high[194:131],
	// instr_address[258:195], zero pad[263:259]
	input  logic [pawp_pkg::S_TDATA_W-1:0]       s_tdata,
	// is_write[0]
	input  logic [0:0]                           s_tuser,
	// Result output
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// hit[0], new_site[1], hit_total[33:2], sites_recorded[39:34]
	output logic [pawp_pkg::M_TDATA_W-1:0]       m_tdata,
	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pawp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pawp_pkg::DATA_W-1:0]          cfg_data
);

	pawp_pkg::cfg_t cfg_q;
	pawp_pkg::access_t in_item;
	pawp_pkg::qent_t push_ent;
	pawp_pkg::qhead_t head;
	logic q_full;
	logic q_push;
	logic q_pop;

	assign cfg_ready = 1'b1;

	// Hold configuration; unknown indexes change nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pawp_pkg::CFG_PATTERN_MODE: cfg_q.pattern_mode <= cfg_data[0];
				pawp_pkg::CFG_TARGET_VALUE: cfg_q.target_value <= cfg_data;
				pawp_pkg::CFG_WINDOW_LOW:   cfg_q.window_low <= cfg_data;
				pawp_pkg::CFG_WINDOW_HIGH:  cfg_q.window_high <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Unpack the access fields
	assign in_item.is_write = s_tuser[0];
	assign in_item.width_code = s_tdata[2:0];
	assign in_item.access_address = s_tdata[66:3];
	assign in_item.data_low = s_tdata[130:67];
	assign in_item.data_high = s_tdata[194:131];
	assign in_item.instr_address = s_tdata[258:195];

	pawp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ent    (push_ent)
	);

	pawp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (push_ent),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head)
	);

	pawp_back #(
		.SITE_SLOTS (SITE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// ===== hdl/pawp_front.sv =====
// Front of the watchpoint: accept accesses, match data and window, push to the queue.
module pawp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pawp_pkg::access_t in_item,
	input  pawp_pkg::cfg_t    cfg,
	input  logic              q_full,
	output logic              q_push,
	output pawp_pkg::qent_t   q_ent
);

	logic [7:0] byte_aa;
	logic [7:0] byte_need;
	logic [pawp_pkg::DATA_W-1:0] low_mask;
	logic [pawp_pkg::DATA_W-1:0] masked_low;
	logic code_ok;
	logic hi_aa;
	logic pat_match;
	logic val_match;
	logic win_block;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			byte_aa[b] = (in_item.data_low[b*8 +: 8] == pawp_pkg::POISON_BYTE);
		end
		hi_aa = 1'b1;
		for (int b = 0; b < 8; b++) begin
			hi_aa = hi_aa & (in_item.data_high[b*8 +: 8] == pawp_pkg::POISON_BYTE);
		end
	end

	// Bytes that take part, capped at one qword
	always_comb begin
		case (in_item.width_code)
			pawp_pkg::WC_1B: byte_need = 8'h01;
			pawp_pkg::WC_2B: byte_need = 8'h03;
			pawp_pkg::WC_4B: byte_need = 8'h0F;
			default:         byte_need = 8'hFF;
		endcase
		for (int b = 0; b < 8; b++) begin
			low_mask[b*8 +: 8] = {8{byte_need[b]}};
		end
	end

	assign masked_low = in_item.data_low & low_mask;
	assign code_ok = (in_item.width_code <= pawp_pkg::WC_16B);

	always_comb begin
		pat_match = &(byte_aa | ~byte_need);
		if (in_item.is_write && in_item.width_code == pawp_pkg::WC_16B) begin
			pat_match = pat_match & hi_aa;
			val_match = (in_item.data_low == cfg.target_value) ||
				(in_item.data_high == cfg.target_value);
		end else if (in_item.is_write) begin
			val_match = (masked_low == cfg.target_value);
		end else begin
			val_match = (in_item.data_low == cfg.target_value);
		end
	end

	assign win_block = ((cfg.window_low | cfg.window_high) != '0) &&
		((in_item.access_address < cfg.window_low) ||
		 (in_item.access_address >= cfg.window_high));

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;
	assign q_ent.hit = code_ok && !win_block && (cfg.pattern_mode ? pat_match : val_match);
	assign q_ent.pc = in_item.instr_address;

	// Accept only while the queue has room
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

endmodule

// ===== hdl/pawp_fifo.sv =====
// Two-entry queue between the classifying front and the site-tracking back.
module pawp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pawp_pkg::qent_t   push_ent,
	output logic              full,
	input  logic              pop,
	output pawp_pkg::qhead_t  head
);

	pawp_pkg::qent_t [1:0] ent_q;
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	assign full = (fill_q == 2'd2);
	assign head.valid = (fill_q != 2'd0);
	assign head.ent = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd2)
		else $error("queue fill out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> fill_q != 2'd0)
		else $error("pop from empty queue");

endmodule

// ===== hdl/pawp_back.sv =====
// Back of the watchpoint: hit counter, site table scan and result register.
module pawp_back #(
	parameter int SITE_SLOTS = pawp_pkg::SITE_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pawp_pkg::qhead_t             head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pawp_pkg::M_TDATA_W-1:0] out_data
);

	localparam int IDX_W = (SITE_SLOTS > 1) ? $clog2(SITE_SLOTS) : 1;
	localparam int SC_W = $clog2(SITE_SLOTS + 1);
	localparam logic [SC_W-1:0] SLOTS_C = SC_W'(SITE_SLOTS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_OUT
	} state_t;

	state_t state_q;
	logic [SC_W-1:0] count_q;
	logic [SC_W-1:0] idx_q;
	logic [pawp_pkg::CNT_W-1:0] hits_q;
	logic [pawp_pkg::ADDR_W-1:0] pc_q;
	logic hit_q;
	logic fresh_q;
	logic out_valid_q;
	logic [pawp_pkg::M_TDATA_W-1:0] out_data_q;

	logic [pawp_pkg::ADDR_W-1:0] site_mem [SITE_SLOTS];
	logic [pawp_pkg::ADDR_W-1:0] rd_q;
	logic mem_we;
	logic [pawp_pkg::ADDR_W-1:0] mem_wdata;
	logic out_free;
	logic last_entry;

	assign pop = (state_q == S_IDLE) && head.valid;
	assign out_free = !out_valid_q || out_ready;
	assign last_entry = ((idx_q + SC_W'(1)) == count_q);

	// New site: recorded straight away from an empty table, or after a miss scan
	always_comb begin
		mem_we = 1'b0;
		mem_wdata = pc_q;
		if (pop && head.ent.hit && count_q == '0) begin
			mem_we = 1'b1;
			mem_wdata = head.ent.pc;
		end else if (state_q == S_CMP && rd_q != pc_q && last_entry) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			site_mem[count_q[IDX_W-1:0]] <= mem_wdata;
		end
		rd_q <= site_mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			hits_q <= '0;
			pc_q <= '0;
			hit_q <= 1'b0;
			fresh_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			// Drop a taken result; S_OUT reloads the register itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						pc_q <= head.ent.pc;
						hit_q <= head.ent.hit;
						fresh_q <= 1'b0;
						idx_q <= '0;
						state_q <= S_OUT;
						if (head.ent.hit) begin
							if (hits_q != pawp_pkg::CNT_MAX) begin
								hits_q <= hits_q + pawp_pkg::CNT_W'(1);
							end
							if (count_q == '0) begin
								count_q <= count_q + SC_W'(1);
								fresh_q <= 1'b1;
							end else if (count_q != SLOTS_C) begin
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rd_q == pc_q) begin
						state_q <= S_OUT;
					end else if (last_entry) begin
						count_q <= count_q + SC_W'(1);
						fresh_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + SC_W'(1);
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q <= {pawp_pkg::SITES_OUT_W'(count_q), hits_q, fresh_q, hit_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_C)
		else $error("site count beyond table size");

	a_fresh_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[0] || !out_data_q[1]))
		else $error("new site flagged without a hit");

	a_hits_step: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q != $past(hits_q) |-> hits_q == $past(hits_q) + pawp_pkg::CNT_W'(1))
		else $error("hit counter moved by more than one");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> idx_q < count_q)
		else $error("site scan beyond recorded entries");

endmodule
